// File: src/hill_pkg.sv
// shared types, constants and mod 26 helpers for the hill cipher block
`default_nettype none
package hill_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_ZERO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_ONE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_TWO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd4;

	localparam logic [4:0] LETTERS = 5'd26;
	localparam logic [7:0] UPPER_BASE = 8'd65;
	localparam logic [7:0] LOWER_BASE = 8'd97;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COF,
		ST_DET,
		ST_SCALE,
		ST_MUL
	} state_t;

	typedef struct packed {
		logic       buf_wr;
		logic       bad_ld;
		logic       cof_wr;
		logic       det_step;
		logic       scale;
		logic       mac;
		logic       mac_last;
		logic       blk_last;
		logic [1:0] idx;
		logic [1:0] row;
		logic [1:0] col;
	} cmd_t;

	typedef struct packed {
		logic       is_letter;
		logic       decrypt;
		logic       out_busy;
		logic [1:0] n;
	} stat_t;

	// x mod 26 for x below 2048, reciprocal estimate then one correction
	function automatic logic [4:0] mod26(input logic [10:0] x);
		logic [17:0] p;
		logic [6:0]  q;
		logic [11:0] r;
		p = 18'(x) * 18'd78;
		q = p[17:11];
		r = 12'(x) - ({5'b0, q} * 12'd26);
		if (r >= 12'd26) begin
			r = r - 12'd26;
		end
		return r[4:0];
	endfunction

	// multiplicative inverse mod 26, zero when none exists
	function automatic logic [4:0] inv26(input logic [4:0] d);
		logic [4:0] v;
		case (d)
			5'd1:    v = 5'd1;
			5'd3:    v = 5'd9;
			5'd5:    v = 5'd21;
			5'd7:    v = 5'd15;
			5'd9:    v = 5'd3;
			5'd11:   v = 5'd19;
			5'd15:   v = 5'd7;
			5'd17:   v = 5'd23;
			5'd19:   v = 5'd11;
			5'd21:   v = 5'd5;
			5'd23:   v = 5'd17;
			5'd25:   v = 5'd25;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: src/hill_dp.sv
// hill cipher datapath: registers, letter buffer, inverse key store, mac unit, output register
`default_nettype none
module hill_dp #(
	parameter int MAX_SIZE = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [hill_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hill_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]                     char_in,
	input  wire hill_pkg::cmd_t                 cmd,
	output hill_pkg::stat_t                     stat,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [7:0]                          char_out,
	output logic                                block_end,
	output logic                                bad_char
);
	import hill_pkg::*;

	localparam int BUF_DEPTH = (MAX_SIZE < 3) ? MAX_SIZE : 3;
	localparam logic [1:0] N_CAP = 2'(BUF_DEPTH);

	logic [1:0]  block_size_q;
	logic [14:0] key0_q;
	logic [14:0] key1_q;
	logic [14:0] key2_q;
	logic        decrypt_q;

	logic [4:0] letter_q [BUF_DEPTH];
	logic       upper_q [BUF_DEPTH];
	logic [4:0] adj_q [9];
	logic [4:0] det_q;
	logic [4:0] acc_q;

	logic       out_valid_q;
	logic [7:0] char_out_q;
	logic       block_end_q;
	logic       bad_char_q;

	logic [1:0] n_raw;
	logic [1:0] n;
	logic       is_upper;
	logic       is_lower;
	logic [4:0] letter_idx;
	logic [3:0] adj_addr;
	logic [4:0] adj_rd;
	logic [1:0] ra, rb, ca, cb;
	logic [9:0] pa, pb;
	logic [4:0] minor3;
	logic [4:0] cof_v;
	logic [4:0] cof_val;
	logic [4:0] det_base;
	logic [4:0] det_next;
	logic [4:0] scaled;
	logic [4:0] mac_m;
	logic [4:0] mac_res;
	logic       out_load;

	function automatic logic [4:0] key_at(input logic [1:0] r, input logic [1:0] c);
		logic [14:0] row;
		logic [4:0]  e;
		case (r)
			2'd0:    row = key0_q;
			2'd1:    row = key1_q;
			default: row = key2_q;
		endcase
		case (c)
			2'd0:    e = row[4:0];
			2'd1:    e = row[9:5];
			default: e = row[14:10];
		endcase
		return (e >= LETTERS) ? (e - LETTERS) : e;
	endfunction

	assign n_raw = (block_size_q == 2'd0) ? 2'd1 : block_size_q;
	assign n = (n_raw > N_CAP) ? N_CAP : n_raw;

	assign is_upper = (char_in >= UPPER_BASE) && (char_in < UPPER_BASE + 8'(LETTERS));
	assign is_lower = (char_in >= LOWER_BASE) && (char_in < LOWER_BASE + 8'(LETTERS));
	assign letter_idx = is_upper ? 5'(char_in - UPPER_BASE) : 5'(char_in - LOWER_BASE);

	assign stat.is_letter = is_upper || is_lower;
	assign stat.decrypt = decrypt_q;
	assign stat.out_busy = out_valid_q && !out_ready;
	assign stat.n = n;

	// cofactors land transposed, so the store ends up holding the adjugate
	always_comb begin
		if (cmd.cof_wr) begin
			adj_addr = 4'(cmd.col) * 4'd3 + 4'(cmd.row);
		end else if (cmd.det_step) begin
			adj_addr = 4'(cmd.col) * 4'd3;
		end else begin
			adj_addr = 4'(cmd.row) * 4'd3 + 4'(cmd.col);
		end
	end

	assign adj_rd = adj_q[adj_addr];

	always_comb begin
		ra = (cmd.row == 2'd0) ? 2'd1 : 2'd0;
		rb = (cmd.row == 2'd2) ? 2'd1 : 2'd2;
		ca = (cmd.col == 2'd0) ? 2'd1 : 2'd0;
		cb = (cmd.col == 2'd2) ? 2'd1 : 2'd2;
		pa = 10'(key_at(ra, ca)) * 10'(key_at(rb, cb));
		pb = 10'(key_at(ra, cb)) * 10'(key_at(rb, ca));
		minor3 = mod26(11'(pa) + 11'd676 - 11'(pb));
		case (n)
			2'd1:    cof_v = 5'd1;
			2'd2:    cof_v = key_at(2'd1 - cmd.row, 2'd1 - cmd.col);
			default: cof_v = minor3;
		endcase
		if ((cmd.row[0] ^ cmd.col[0]) && (cof_v != 5'd0)) begin
			cof_val = LETTERS - cof_v;
		end else begin
			cof_val = cof_v;
		end
	end

	assign det_base = (cmd.col == 2'd0) ? 5'd0 : det_q;
	assign det_next = mod26(11'(det_base) + 11'(10'(key_at(2'd0, cmd.col)) * 10'(adj_rd)));
	assign scaled = mod26(11'(10'(adj_rd) * 10'(inv26(det_q))));

	assign mac_m = decrypt_q ? adj_rd : key_at(cmd.row, cmd.col);
	assign mac_res = mod26(11'(acc_q) + 11'(10'(mac_m) * 10'(letter_q[cmd.col])));

	assign out_load = cmd.bad_ld || (cmd.mac && cmd.mac_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 2'd2;
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_SIZE:   block_size_q <= cfg_data[1:0];
				REG_KEY_ROW_ZERO: key0_q <= cfg_data;
				REG_KEY_ROW_ONE:  key1_q <= cfg_data;
				REG_KEY_ROW_TWO:  key2_q <= cfg_data;
				REG_DECRYPT_MODE: decrypt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				letter_q[i] <= '0;
				upper_q[i] <= 1'b0;
			end
		end else if (cmd.buf_wr) begin
			letter_q[cmd.idx] <= letter_idx;
			upper_q[cmd.idx] <= is_upper;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cof_wr) begin
			adj_q[adj_addr] <= cof_val;
		end else if (cmd.scale) begin
			adj_q[adj_addr] <= scaled;
		end
		if (cmd.det_step) begin
			det_q <= det_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.mac) begin
			acc_q <= cmd.mac_last ? 5'd0 : mac_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bad_ld) begin
			char_out_q <= 8'd0;
			block_end_q <= 1'b0;
			bad_char_q <= 1'b1;
		end else if (cmd.mac && cmd.mac_last) begin
			char_out_q <= 8'(mac_res) + (upper_q[cmd.row] ? UPPER_BASE : LOWER_BASE);
			block_end_q <= cmd.blk_last;
			bad_char_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out = char_out_q;
	assign block_end = block_end_q;
	assign bad_char = bad_char_q;

endmodule
`default_nettype wire

// File: src/hill_ctrl.sv
// hill cipher controller: fill count, inverse sweep sequencing and block multiply steps
`default_nettype none
module hill_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [hill_pkg::CFG_IDX_W-1:0] cfg_index,
	output logic                                cfg_ready,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire hill_pkg::stat_t                stat,
	output hill_pkg::cmd_t                      cmd
);
	import hill_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] row_q, row_d;
	logic [1:0] col_q, col_d;
	logic [1:0] fill_q, fill_d;
	logic       inv_ready_q, inv_ready_d;

	logic [1:0] n_m1;
	logic       col_last;
	logic       row_last;
	logic [1:0] wr_idx;
	logic [1:0] fill_next;

	assign cfg_ready = 1'b1;

	assign n_m1 = stat.n - 2'd1;
	assign col_last = (col_q == n_m1);
	assign row_last = (row_q == n_m1);
	assign wr_idx = (fill_q >= stat.n) ? 2'd0 : fill_q;
	assign fill_next = wr_idx + 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			fill_q <= '0;
			inv_ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			col_q <= col_d;
			fill_q <= fill_d;
			inv_ready_q <= inv_ready_d;
		end
	end

	always_comb begin
		state_d = state_q;
		row_d = row_q;
		col_d = col_q;
		fill_d = fill_q;
		inv_ready_d = inv_ready_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.idx = wr_idx;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.mac_last = col_last;
		cmd.blk_last = row_last;

		case (state_q)
			ST_IDLE: begin
				in_ready = !stat.out_busy;
				if (in_valid && !stat.out_busy) begin
					if (!stat.is_letter) begin
						cmd.bad_ld = 1'b1;
					end else begin
						cmd.buf_wr = 1'b1;
						if (fill_next == stat.n) begin
							fill_d = 2'd0;
							row_d = 2'd0;
							col_d = 2'd0;
							if (stat.decrypt && !inv_ready_q) begin
								state_d = ST_COF;
							end else begin
								state_d = ST_MUL;
							end
						end else begin
							fill_d = fill_next;
						end
					end
				end
			end
			ST_COF: begin
				cmd.cof_wr = 1'b1;
				if (col_last) begin
					col_d = 2'd0;
					row_d = row_q + 2'd1;
				end else begin
					col_d = col_q + 2'd1;
				end
				if (col_last && row_last) begin
					row_d = 2'd0;
					state_d = ST_DET;
				end
			end
			ST_DET: begin
				cmd.det_step = 1'b1;
				if (col_last) begin
					col_d = 2'd0;
					state_d = ST_SCALE;
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				if (col_last) begin
					col_d = 2'd0;
					row_d = row_q + 2'd1;
				end else begin
					col_d = col_q + 2'd1;
				end
				if (col_last && row_last) begin
					row_d = 2'd0;
					inv_ready_d = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				// last column needs a free output register
				if (!(col_last && stat.out_busy)) begin
					cmd.mac = 1'b1;
					if (col_last) begin
						col_d = 2'd0;
						row_d = row_q + 2'd1;
					end else begin
						col_d = col_q + 2'd1;
					end
					if (col_last && row_last) begin
						row_d = 2'd0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cfg_valid) begin
			if (cfg_index == REG_BLOCK_SIZE) begin
				fill_d = 2'd0;
				inv_ready_d = 1'b0;
			end else if (cfg_index == REG_KEY_ROW_ZERO || cfg_index == REG_KEY_ROW_ONE ||
				cfg_index == REG_KEY_ROW_TWO) begin
				inv_ready_d = 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < stat.n)
		else $error("fill count reached block size");

	a_mac_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac && cmd.mac_last |-> !stat.out_busy)
		else $error("result written over a pending transfer");

	a_decrypt_inverse_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && stat.decrypt |-> inv_ready_q)
		else $error("decrypt multiply without inverse key");

	a_cof_to_det: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COF |=> state_q == ST_COF || state_q == ST_DET)
		else $error("cofactor sweep left early");
`endif

endmodule
`default_nettype wire

// File: src/hill_cipher_block_crypt.sv
// hill cipher block crypt top level: controller plus datapath
`default_nettype none
// Hill cipher over the 26 letters with a 1x1 to 3x3 key. Letters A-Z and a-z
// are taken one per transfer and collected into a block of n letters, n being
// block_size with 0 read as 1, capped at MAX_SIZE. A closed block goes through
// one shared 5x5 multiply-accumulate unit, one key entry per cycle unless a
// row's last entry waits for a free output register, each result letter
// leaving through the output register on its row's last step. In decrypt mode
// after a key or block size write the first block first rebuilds the inverse
// key in cofactor, determinant and scaling sweeps. A non-letter byte gives one
// result with bad_char set and leaves the buffer alone. A key whose determinant
// has no inverse mod 26 decrypts to all 'A' or 'a'.
module hill_cipher_block_crypt #(
	parameter int MAX_SIZE = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [hill_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hill_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     char_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [7:0]                          char_out,
	output logic                                block_end,
	output logic                                bad_char
);
	import hill_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	hill_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_ready (cfg_ready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hill_dp #(
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_in   (char_in),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.char_out  (char_out),
		.block_end (block_end),
		.bad_char  (bad_char)
	);

endmodule
`default_nettype wire
